/* src/csa_pkg.sv */
// shared widths, types and constants for the cosine similarity accumulator
package csa_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int LOG2_MAX_LEN = 16;
  localparam int FRAC         = DATA_WIDTH - 1;
  localparam int ACC_RAW      = 2 * DATA_WIDTH + LOG2_MAX_LEN;
  localparam int ACC_W        = (ACC_RAW > 62) ? 62 : ACC_RAW;
  localparam int HALF_W       = (ACC_W + 1) / 2;
  localparam int MUL_W        = (HALF_W + 1 > DATA_WIDTH) ? HALF_W + 1 : DATA_WIDTH;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int WIDE_W       = 2 * ACC_W;
  localparam int CMP_W        = 2 * DATA_WIDTH + WIDE_W;
  localparam int KW           = $clog2(DATA_WIDTH);

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic        [DATA_WIDTH-1:0] q_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic        [ACC_W-1:0]      mag_t;
  typedef logic signed [MUL_W-1:0]      mul_op_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic        [WIDE_W-1:0]     wide_t;
  typedef logic        [CMP_W-1:0]      cmp_t;

  localparam q_t Q_ONE     = {1'b1, {FRAC{1'b0}}};
  localparam q_t Q_MAX_POS = {1'b0, {FRAC{1'b1}}};

endpackage

/* src/csa_mul.sv */
// shared signed multiplier with registered product
module csa_mul
  import csa_pkg::*;
(
  input  logic    clk,
  input  mul_op_t op_a,
  input  mul_op_t op_b,
  output prod_t   prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* src/csa_search.sv */
// bit-serial search for the largest q with q*q*p <= dot_sq * 2^(2*frac)
module csa_search
  import csa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  wide_t p,
  input  wide_t dot_sq,
  output logic  done,
  output q_t    q
);

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_ADD_T,
    SR_ADD_P,
    SR_TEST
  } state_t;

  state_t          state;
  logic [KW-1:0]   k;
  cmp_t            s;
  cmp_t            t;
  cmp_t            cand;
  cmp_t            r_val;
  cmp_t            p_ext;

  assign r_val = cmp_t'(dot_sq) << (2 * FRAC);
  assign p_ext = cmp_t'(p);

  // s tracks q*q*p and t tracks q*p, so each trial bit costs shifts and adds only
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SR_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        SR_IDLE: begin
          done <= 1'b0;
          if (start) begin
            q     <= '0;
            s     <= '0;
            t     <= '0;
            k     <= KW'(FRAC);
            state <= SR_ADD_T;
          end
        end
        SR_ADD_T: begin
          cand  <= s + (t << (int'(k) + 1));
          state <= SR_ADD_P;
        end
        SR_ADD_P: begin
          cand  <= cand + (p_ext << {k, 1'b0});
          state <= SR_TEST;
        end
        SR_TEST: begin
          if (cand <= r_val) begin
            s    <= cand;
            t    <= t + (p_ext << k);
            q[k] <= 1'b1;
          end
          done <= (k == '0);
          if (k == '0) begin
            state <= SR_IDLE;
          end else begin
            k     <= k - KW'(1);
            state <= SR_ADD_T;
          end
        end
        default: state <= SR_IDLE;
      endcase
    end
  end

endmodule

/* src/cosine_similarity_accumulator.sv */
// cosine similarity accumulator: sequencer, saturating sums and result register
// a transaction that is not last is accepted and then runs three products through the
// shared multiplier before the sequencer returns to idle
// a last transaction then forms two 4-pass wide products on the multiplier, |dot|^2 and
// norm_a*norm_b, and runs a bit-serial search for the result; with a zero norm the
// search is skipped and the result is flagged zero_norm
// synchronous reset clears the three sums, the sequencer and the output valid
module cosine_similarity_accumulator
  import csa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t elem_a,
  input  sample_t elem_b,
  input  logic    last_item,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t similarity,
  output logic    zero_norm
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN,
    ST_BIG,
    ST_SEARCH,
    ST_OUT
  } state_t;

  typedef logic signed [ACC_W:0]      sum_t;
  typedef logic        [2*HALF_W-1:0] pad_t;

  localparam logic [1:0] MAC_DOT  = 2'd0;
  localparam logic [1:0] MAC_NA   = 2'd1;
  localparam logic [1:0] MAC_NB   = 2'd2;
  localparam logic [1:0] BIG_LAST = 2'd3;

  localparam acc_t ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t ACC_ZERO = '0;

  state_t  state;
  logic [1:0] step;
  logic    phase;
  logic    sel;
  sample_t a_reg;
  sample_t b_reg;
  logic    last_reg;
  acc_t    dot_sum;
  acc_t    norm_a_sum;
  acc_t    norm_b_sum;
  logic    neg;
  mag_t    adot;
  wide_t   wide;
  wide_t   wide_sum;
  wide_t   dot_sq;
  wide_t   nprod;
  logic    srch_start;
  logic    srch_done;
  q_t      srch_q;
  q_t      q_cap;
  sample_t sim_val;
  sample_t res_sim;
  logic    res_zn;
  mul_op_t mul_a;
  mul_op_t mul_b;
  prod_t   prod;
  mag_t    big_x;
  mag_t    big_y;
  pad_t    x_pad;
  pad_t    y_pad;

  function automatic acc_t sat_add(acc_t acc, prod_t p);
    sum_t s;
    acc_t r;
    s = sum_t'(acc) + sum_t'(p);
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = acc_t'(s);
    end
    return r;
  endfunction

  assign in_ready = (state == ST_IDLE);

  // operand select for the shared multiplier
  assign big_x = sel ? mag_t'(norm_a_sum) : adot;
  assign big_y = sel ? mag_t'(norm_b_sum) : adot;
  assign x_pad = pad_t'(big_x);
  assign y_pad = pad_t'(big_y);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_BIG) begin
      mul_a = mul_op_t'({1'b0, step[1] ? x_pad[2*HALF_W-1:HALF_W] : x_pad[HALF_W-1:0]});
      mul_b = mul_op_t'({1'b0, step[0] ? y_pad[2*HALF_W-1:HALF_W] : y_pad[HALF_W-1:0]});
    end else begin
      case (step)
        MAC_DOT: begin
          mul_a = mul_op_t'(a_reg);
          mul_b = mul_op_t'(b_reg);
        end
        MAC_NA: begin
          mul_a = mul_op_t'(a_reg);
          mul_b = mul_op_t'(a_reg);
        end
        default: begin
          mul_a = mul_op_t'(b_reg);
          mul_b = mul_op_t'(b_reg);
        end
      endcase
    end
  end

  // partial product weight is HALF_W times the number of upper halves involved
  assign wide_sum = wide + (wide_t'(prod) << (HALF_W * (int'(step[1]) + int'(step[0]))));

  assign q_cap   = (srch_q > Q_ONE) ? Q_ONE : srch_q;
  assign sim_val = neg ? sample_t'(~q_cap + q_t'(1))
                       : sample_t'((q_cap == Q_ONE) ? Q_MAX_POS : q_cap);

  csa_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  csa_search u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (srch_start),
    .p      (nprod),
    .dot_sq (dot_sq),
    .done   (srch_done),
    .q      (srch_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= MAC_DOT;
      phase      <= 1'b0;
      sel        <= 1'b0;
      srch_start <= 1'b0;
      out_valid  <= 1'b0;
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
    end else begin
      // the result state reloads the output register itself
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            a_reg    <= elem_a;
            b_reg    <= elem_b;
            last_reg <= last_item;
            step     <= MAC_DOT;
            phase    <= 1'b0;
            state    <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            case (step)
              MAC_DOT: dot_sum    <= sat_add(dot_sum, prod);
              MAC_NA:  norm_a_sum <= sat_add(norm_a_sum, prod);
              default: norm_b_sum <= sat_add(norm_b_sum, prod);
            endcase
            if (step == MAC_NB) begin
              step  <= MAC_DOT;
              state <= last_reg ? ST_FIN : ST_IDLE;
            end else begin
              step <= step + 2'd1;
            end
          end
        end
        ST_FIN: begin
          if (norm_a_sum <= ACC_ZERO || norm_b_sum <= ACC_ZERO) begin
            res_sim <= '0;
            res_zn  <= 1'b1;
            state   <= ST_OUT;
          end else begin
            neg   <= dot_sum[ACC_W-1];
            adot  <= dot_sum[ACC_W-1] ? mag_t'(-dot_sum) : mag_t'(dot_sum);
            sel   <= 1'b0;
            step  <= MAC_DOT;
            phase <= 1'b0;
            wide  <= '0;
            state <= ST_BIG;
          end
        end
        ST_BIG: begin
          // first pass squares |dot|, second pass multiplies the two norms
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (step == BIG_LAST) begin
              step <= MAC_DOT;
              wide <= '0;
              if (!sel) begin
                dot_sq <= wide_sum;
                sel    <= 1'b1;
              end else begin
                nprod      <= wide_sum;
                srch_start <= 1'b1;
                state      <= ST_SEARCH;
              end
            end else begin
              step <= step + 2'd1;
              wide <= wide_sum;
            end
          end
        end
        ST_SEARCH: begin
          srch_start <= 1'b0;
          if (srch_done) begin
            res_sim <= sim_val;
            res_zn  <= 1'b0;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            similarity <= res_sim;
            zero_norm  <= res_zn;
            out_valid  <= 1'b1;
            dot_sum    <= '0;
            norm_a_sum <= '0;
            norm_b_sum <= '0;
            sel        <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
